>>> rtl/rgbs_pkg.sv
// ----------------------------------------------------------------------------
// rgbs_pkg: shared constants and types for the RGB 3x3 sharpen block
// Channel and pixel widths, register indexes and reset values.
// ----------------------------------------------------------------------------
package rgbs_pkg;

  localparam int CHAN_W  = 8;
  localparam int NCHAN   = 3;
  localparam int PIX_W   = CHAN_W * NCHAN;

  // geometry and strength registers
  localparam int FW_W    = 12;
  localparam int FH_W    = 16;
  localparam int AMT_W   = 12;
  localparam int ROW_W   = FH_W + 1;   // row can step one past the height
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHARPEN_AMOUNT = 2'd2;

  localparam logic [FW_W-1:0]  FW_RESET  = 12'd640;
  localparam logic [FH_W-1:0]  FH_RESET  = 16'd480;
  localparam logic [AMT_W-1:0] AMT_RESET = 12'd256;

  // kernel arithmetic
  localparam int NB_W   = CHAN_W + 3;          // sum of eight neighbours
  localparam int DIFF_W = CHAN_W + 4;          // 8*centre - neighbours, signed
  localparam int MUL_W  = AMT_W + 1 + DIFF_W;  // amount * diff, signed
  localparam int ACC_W  = MUL_W + 1;

  typedef logic [PIX_W-1:0]  pix_t;
  typedef logic [CHAN_W-1:0] chan_t;
  typedef logic signed [DIFF_W-1:0] diff_t;

endpackage

>>> rtl/rgbs_in_if.sv
// ----------------------------------------------------------------------------
// rgbs_in_if: input pixel channel
// Valid/ready channel carrying one raster pixel or a pad item.
// ----------------------------------------------------------------------------
interface rgbs_in_if;
  logic                        valid;
  logic                        ready;
  logic [rgbs_pkg::CHAN_W-1:0] in_red;
  logic [rgbs_pkg::CHAN_W-1:0] in_green;
  logic [rgbs_pkg::CHAN_W-1:0] in_blue;
  logic                        pad_item;

  modport source (output valid, in_red, in_green, in_blue, pad_item, input ready);
  modport sink   (input valid, in_red, in_green, in_blue, pad_item, output ready);
endinterface

>>> rtl/rgbs_out_if.sv
// ----------------------------------------------------------------------------
// rgbs_out_if: output pixel channel
// Valid/ready channel carrying one sharpened pixel and its frame end flag.
// ----------------------------------------------------------------------------
interface rgbs_out_if;
  logic                        valid;
  logic                        ready;
  logic [rgbs_pkg::CHAN_W-1:0] out_red;
  logic [rgbs_pkg::CHAN_W-1:0] out_green;
  logic [rgbs_pkg::CHAN_W-1:0] out_blue;
  logic                        frame_end;

  modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

>>> rtl/rgb_sharpen_3x3_blend.sv
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_blend: streaming 3x3 sharpen with adjustable strength
//
// in_ch carries raster RGB pixels, one per item; pad_item marks a dummy item
// that moves the raster position on with black data. out_ch carries the
// sharpened pixels in raster order, frame_end on the last one of a frame.
// Each output belongs to the input one row plus one pixel earlier, so W+1
// pad items after a frame flush its tail. Border pixels pass through.
// Throughput is one item per clock while out_ch is not stalled. The edge
// that accepts an item registers its line store read; the kernel sum is then
// registered in stage 2 and the blend multiply in the output register.
// The three stages close up bubbles, so in_ch.ready only drops once the
// output register and both stages are full and out_ch.ready is low.
// cfg_we writes frame_width (0), frame_height (1) or sharpen_amount (2);
// a geometry write restarts the frame. Write only while the block is idle.
// Reset restores 640 x 480 and amount 1.0 and clears counters and window.
// The line stores are not cleared; no unwritten entry ever reaches out_ch.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_blend #(
  parameter int MAX_WIDTH = rgbs_pkg::MAX_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rgbs_in_if.sink                         in_ch,
  rgbs_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [rgbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rgbs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import rgbs_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  // configuration
  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [AMT_W-1:0] amount_r;
  logic [WW-1:0]    w_eff;
  logic [FH_W-1:0]  h_eff;
  logic             restart;

  // raster position and output position
  logic [CW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CW-1:0]    oc_col_r, oc_col_nxt;
  logic [FH_W-1:0]  oc_row_r, oc_row_nxt;

  logic [CW-1:0]    c_acc;
  logic [WW-1:0]    c_inc;
  logic [CW-1:0]    tail_addr;
  logic             acc, acc_emit, acc_last, acc_int, col_wrap;
  pix_t             acc_px;

  // line stores
  pix_t upper_mem [MAX_WIDTH];
  pix_t middle_mem [MAX_WIDTH];
  pix_t ram_up_r, ram_mid_r, ram_tail_r;
  logic fwd_c_r, fwd_t_r;
  pix_t fwd_umid_r, fwd_px_r;

  // stage 1: window and kernel sum
  logic          s1_v_r, s1_en, s1_fire;
  logic [CW-1:0] s1_c_r;
  pix_t          s1_px_r;
  logic          s1_c0_r, s1_emit_r, s1_last_r, s1_int_r;
  pix_t          win_r [6];
  pix_t          up_s1, mid_s1, tail_s1, pass_s1;
  pix_t          nbr [8];
  logic [NB_W-1:0] nb_sum [NCHAN];
  chan_t         ctr_s1 [NCHAN];
  diff_t         diff_s1 [NCHAN];

  // stage 2: blend
  logic  s2_v_r, s2_en;
  logic  s2_last_r, s2_int_r;
  pix_t  s2_pass_r;
  chan_t s2_ctr_r [NCHAN];
  diff_t s2_diff_r [NCHAN];
  logic signed [MUL_W-1:0] prod [NCHAN];
  logic signed [ACC_W-1:0] blend [NCHAN];
  pix_t  sharp_s2, o_pix_nxt;

  // output register
  logic o_v_r, out_en;
  pix_t o_pix_r;
  logic o_last_r;

  // ---------------------------------------------------------------- control
  assign out_en  = !o_v_r || out_ch.ready;
  assign s2_en   = !s2_v_r || out_en;
  assign s1_en   = !s1_v_r || s2_en;
  assign s1_fire = s1_v_r && s2_en;
  assign acc     = in_ch.valid && s1_en;
  assign in_ch.ready = s1_en;

  assign restart = cfg_we && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT);

  always_comb begin
    if (fw_r == '0) begin
      w_eff = WW'(1);
    end else if (32'(fw_r) > MAX_WIDTH) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(fw_r);
    end
    h_eff = (fh_r == '0) ? FH_W'(1) : fh_r;
  end

  always_comb begin
    c_acc     = (WW'(col_r) >= w_eff) ? '0 : col_r;
    c_inc     = WW'(c_acc) + WW'(1);
    col_wrap  = c_inc >= w_eff;
    tail_addr = CW'(w_eff - WW'(1));
    acc_emit  = (c_acc == '0) ? (row_r >= ROW_W'(2)) : (row_r >= ROW_W'(1));
    acc_int   = (row_r >= ROW_W'(2)) && ((row_r + ROW_W'(1)) <= ROW_W'(h_eff)) &&
                (c_acc >= CW'(2)) && (c_inc <= w_eff);
    acc_last  = (WW'(oc_col_r) == w_eff - WW'(1)) && (oc_row_r == h_eff - FH_W'(1));
    acc_px    = in_ch.pad_item ? '0 : {in_ch.in_red, in_ch.in_green, in_ch.in_blue};

    col_nxt    = col_wrap ? '0 : CW'(c_inc);
    row_nxt    = col_wrap ? row_r + ROW_W'(1) : row_r;
    oc_col_nxt = oc_col_r;
    oc_row_nxt = oc_row_r;
    if (acc_emit) begin
      if (acc_last) begin
        col_nxt    = '0;
        row_nxt    = '0;
        oc_col_nxt = '0;
        oc_row_nxt = '0;
      end else if (WW'(oc_col_r) + WW'(1) >= w_eff) begin
        oc_col_nxt = '0;
        oc_row_nxt = oc_row_r + FH_W'(1);
      end else begin
        oc_col_nxt = oc_col_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r     <= FW_RESET;
      fh_r     <= FH_RESET;
      amount_r <= AMT_RESET;
      col_r    <= '0;
      row_r    <= '0;
      oc_col_r <= '0;
      oc_row_r <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      o_v_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_FRAME_WIDTH:    fw_r     <= cfg_wdata[FW_W-1:0];
          CFG_FRAME_HEIGHT:   fh_r     <= cfg_wdata[FH_W-1:0];
          CFG_SHARPEN_AMOUNT: amount_r <= cfg_wdata[AMT_W-1:0];
          default: ;
        endcase
      end
      if (restart) begin
        col_r    <= '0;
        row_r    <= '0;
        oc_col_r <= '0;
        oc_row_r <= '0;
        for (int i = 0; i < 6; i++) begin
          win_r[i] <= '0;
        end
      end else begin
        if (acc) begin
          col_r    <= col_nxt;
          row_r    <= row_nxt;
          oc_col_r <= oc_col_nxt;
          oc_row_r <= oc_row_nxt;
        end
        if (s1_fire) begin
          win_r[3] <= win_r[0];
          win_r[4] <= win_r[1];
          win_r[5] <= win_r[2];
          win_r[0] <= up_s1;
          win_r[1] <= mid_s1;
          win_r[2] <= s1_px_r;
        end
      end
      if (s1_en) begin
        s1_v_r <= in_ch.valid;
      end
      if (s2_en) begin
        s2_v_r <= s1_v_r && s1_emit_r;
      end
      if (out_en) begin
        o_v_r <= s2_v_r;
      end
    end
  end

  // ------------------------------------------------------------ line stores
  // Stage 1 writes the slot that a newly accepted item may read in the same
  // cycle (width 1, or the tail at a row start), so that write is bypassed.
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      upper_mem[s1_c_r]  <= mid_s1;
      middle_mem[s1_c_r] <= s1_px_r;
    end
    if (acc) begin
      ram_up_r   <= upper_mem[c_acc];
      ram_mid_r  <= middle_mem[c_acc];
      ram_tail_r <= upper_mem[tail_addr];
      fwd_c_r    <= s1_fire && (s1_c_r == c_acc);
      fwd_t_r    <= s1_fire && (s1_c_r == tail_addr);
      fwd_umid_r <= mid_s1;
      fwd_px_r   <= s1_px_r;
    end
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_c_r    <= c_acc;
      s1_px_r   <= acc_px;
      s1_c0_r   <= c_acc == '0;
      s1_emit_r <= acc_emit;
      s1_last_r <= acc_last;
      s1_int_r  <= acc_int;
    end
  end

  assign up_s1   = fwd_c_r ? fwd_umid_r : ram_up_r;
  assign mid_s1  = fwd_c_r ? fwd_px_r : ram_mid_r;
  assign tail_s1 = fwd_t_r ? fwd_umid_r : ram_tail_r;
  // column 0 emits the end of the row above; elsewhere the centre passes
  assign pass_s1 = s1_c0_r ? tail_s1 : win_r[1];

  always_comb begin
    nbr[0] = win_r[0];
    nbr[1] = win_r[2];
    nbr[2] = win_r[3];
    nbr[3] = win_r[4];
    nbr[4] = win_r[5];
    nbr[5] = up_s1;
    nbr[6] = mid_s1;
    nbr[7] = s1_px_r;
    for (int k = 0; k < NCHAN; k++) begin
      nb_sum[k] = '0;
      for (int j = 0; j < 8; j++) begin
        nb_sum[k] = nb_sum[k] + NB_W'(nbr[j][k*CHAN_W +: CHAN_W]);
      end
      ctr_s1[k]  = win_r[1][k*CHAN_W +: CHAN_W];
      diff_s1[k] = DIFF_W'({ctr_s1[k], 3'b000}) - DIFF_W'(nb_sum[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_last_r <= s1_last_r;
      s2_int_r  <= s1_int_r;
      s2_pass_r <= pass_s1;
      for (int k = 0; k < NCHAN; k++) begin
        s2_ctr_r[k]  <= ctr_s1[k];
        s2_diff_r[k] <= diff_s1[k];
      end
    end
  end

  // ---------------------------------------------------------------- stage 2
  // centre*256 + amount*diff, clamped to 0..65535, top byte kept
  always_comb begin
    for (int k = 0; k < NCHAN; k++) begin
      prod[k]  = $signed({1'b0, amount_r}) * s2_diff_r[k];
      blend[k] = ACC_W'(prod[k]) + $signed(ACC_W'({s2_ctr_r[k], 8'h00}));
      if (blend[k][ACC_W-1]) begin
        sharp_s2[k*CHAN_W +: CHAN_W] = '0;
      end else if (|blend[k][ACC_W-2:16]) begin
        sharp_s2[k*CHAN_W +: CHAN_W] = '1;
      end else begin
        sharp_s2[k*CHAN_W +: CHAN_W] = blend[k][15:8];
      end
    end
    o_pix_nxt = s2_int_r ? sharp_s2 : s2_pass_r;
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      o_pix_r  <= o_pix_nxt;
      o_last_r <= s2_last_r;
    end
  end

  assign out_ch.valid     = o_v_r;
  assign out_ch.out_red   = o_pix_r[2*CHAN_W +: CHAN_W];
  assign out_ch.out_green = o_pix_r[CHAN_W +: CHAN_W];
  assign out_ch.out_blue  = o_pix_r[0 +: CHAN_W];
  assign out_ch.frame_end = o_last_r;

  // ------------------------------------------------------------- assertions
  a_emit_reaches_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_emit_r) |=> s2_v_r)
    else $error("emitting item lost between stage 1 and stage 2");

  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_v_r && s2_v_r && o_v_r && !out_ch.ready))
    else $error("input stalled with room in the pipeline");

  a_frame_end_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && acc_emit && acc_last) |=>
      (col_r == '0 && row_r == '0 && oc_col_r == '0 && oc_row_r == '0))
    else $error("raster position not cleared after frame end");

  a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w_eff)
    else $error("column counter beyond frame width");

endmodule
